>>> src/dla_pkg.sv
// Shared types and constants for the DHCP lease allocator.
// No dependencies; imported by dla_cmp, dla_ctrl and dhcp_lease_allocator.
`default_nettype none

package dla_pkg;

   localparam int LEASE_ENTRIES_DEF = 16;

   localparam int MAC_W     = 48;
   localparam int TIME_W    = 32;
   localparam int ADDR_W    = 32;
   localparam int COUNT_W   = 32;
   localparam int SLOT_W    = 4;
   localparam int OCTET_W   = 8;
   localparam int ENTRY_W   = MAC_W + TIME_W;

   // request tdata: client_mac, now_seconds
   localparam int REQ_DATA_W   = 80;
   // response tdata: lease_slot, client_address, was_known, allocation_total
   localparam int RSP_FIELDS_W = SLOT_W + ADDR_W + 1 + COUNT_W;
   localparam int RSP_DATA_W   = 72;

   localparam logic [ADDR_W-1:0] SERVER_RESET   = '0;
   localparam logic [TIME_W-1:0] DURATION_RESET = TIME_W'(60 * 60);
   localparam logic [ADDR_W-1:0] PREFIX_MASK    = 32'hFFFF_FF00;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SERVER_ADDRESS = 1'b0,
      CSR_LEASE_DURATION = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_ALLOCATE = 1'b0,
      KIND_RELEASE  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } state_type;

   // compare unit verdict on the entry under inspection
   typedef struct packed {
      logic mac_hit;
      logic slot_free;
   } probe_type;

endpackage

`default_nettype wire

>>> src/dla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the lease entries (MAC and expiry).
`default_nettype none

module dla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/dla_cmp.sv
// Shared compare unit: checks one lease entry against the client MAC and time.
// Depends on dla_pkg.
`default_nettype none

module dla_cmp (
   input  wire logic [dla_pkg::ENTRY_W-1:0] entry_data,
   input  wire logic                        entry_used,
   input  wire logic [dla_pkg::MAC_W-1:0]   key_mac,
   input  wire logic [dla_pkg::TIME_W-1:0]  key_now,
   output dla_pkg::probe_type               probe
);
   import dla_pkg::*;

   logic [MAC_W-1:0]  entry_mac;
   logic [TIME_W-1:0] entry_expiry;

   assign entry_mac    = entry_data[MAC_W-1:0];
   assign entry_expiry = entry_data[ENTRY_W-1:MAC_W];

   always_comb begin
      probe.mac_hit   = entry_used && (entry_mac == key_mac);
      // expiry equal to now still counts as live
      probe.slot_free = !entry_used || (entry_expiry < key_now);
   end

endmodule

`default_nettype wire

>>> src/dla_ctrl.sv
// Sequencer for the lease table: walks entries one per cycle, keeps used
// marks and the allocation count, and holds the response register.
// Depends on dla_pkg; drives dla_ram and reads the verdict of dla_cmp.
`default_nettype none

module dla_ctrl #(
   parameter int LEASE_ENTRIES = dla_pkg::LEASE_ENTRIES_DEF,
   parameter int IDX_W         = (LEASE_ENTRIES > 1) ? $clog2(LEASE_ENTRIES) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic                           req_kind,
   input  wire logic [dla_pkg::MAC_W-1:0]      req_mac,
   input  wire logic [dla_pkg::TIME_W-1:0]     req_now,
   input  wire logic [dla_pkg::ADDR_W-1:0]     server_address,
   input  wire logic [dla_pkg::TIME_W-1:0]     lease_duration,
   output logic                                ram_wr_en,
   output logic      [IDX_W-1:0]               ram_wr_addr,
   output logic      [dla_pkg::ENTRY_W-1:0]    ram_wr_data,
   output logic                                ram_rd_en,
   output logic      [IDX_W-1:0]               ram_rd_addr,
   input  wire dla_pkg::probe_type             probe,
   output logic                                probe_used,
   output logic      [dla_pkg::MAC_W-1:0]      key_mac,
   output logic      [dla_pkg::TIME_W-1:0]     key_now,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [dla_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import dla_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LEASE_ENTRIES - 1);

   state_type                state_ff, state_in;
   kind_type                 kind_ff, kind_in;
   logic [MAC_W-1:0]         mac_ff, mac_in;
   logic [TIME_W-1:0]        now_ff, now_in;
   logic [IDX_W-1:0]         cur_ff, cur_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic                     known_ff, known_in;
   logic                     free_ff, free_in;
   logic [LEASE_ENTRIES-1:0] used_ff, used_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic                     last_entry;
   logic [IDX_W-1:0]         next_idx;
   logic                     out_free;
   logic [OCTET_W-1:0]       slot_oct;
   logic [OCTET_W-1:0]       low_octet;
   logic [ADDR_W-1:0]        client_address;

   assign accept     = req_tvalid && req_tready;
   assign last_entry = (cur_ff == LAST_IDX);
   assign next_idx   = last_entry ? '0 : IDX_W'(cur_ff + 1'b1);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign probe_used = used_ff[cur_ff];
   assign key_mac    = mac_ff;
   assign key_now    = now_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // address low octet wraps without touching the prefix
   assign slot_oct       = OCTET_W'(slot_ff);
   assign low_octet      = OCTET_W'(server_address[OCTET_W-1:0] + 8'd1 + slot_oct);
   assign client_address = (server_address & PREFIX_MASK)
                           | {{(ADDR_W-OCTET_W){1'b0}}, low_octet};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (kind_ff == KIND_RELEASE) begin
               if (last_entry) state_in = ST_IDLE;
            end else if (probe.mac_hit || last_entry) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs toward the request side and the RAM
   always_comb begin
      req_tready  = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = next_idx;
      ram_wr_en   = 1'b0;
      ram_wr_addr = slot_ff;
      ram_wr_data = {TIME_W'(now_ff + lease_duration), mac_ff};
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            ram_rd_en   = req_tvalid;
            ram_rd_addr = '0;
         end
         ST_SCAN:  ram_rd_en = 1'b1;
         ST_WRITE: ram_wr_en = 1'b1;
         ST_DONE:  ram_rd_en = 1'b0;
         default:  ram_rd_en = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      kind_in      = kind_ff;
      mac_in       = mac_ff;
      now_in       = now_ff;
      cur_in       = cur_ff;
      slot_in      = slot_ff;
      known_in     = known_ff;
      free_in      = free_ff;
      used_in      = used_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in  = kind_type'(req_kind);
               mac_in   = req_mac;
               now_in   = req_now;
               cur_in   = '0;
               slot_in  = '0;
               known_in = 1'b0;
               free_in  = 1'b0;
            end
         end
         ST_SCAN: begin
            cur_in = next_idx;
            if (kind_ff == KIND_RELEASE) begin
               if (probe.mac_hit) used_in[cur_ff] = 1'b0;
            end else if (probe.mac_hit) begin
               slot_in  = cur_ff;
               known_in = 1'b1;
            end else if (!free_ff && probe.slot_free) begin
               // first unused or expired entry wins
               slot_in = cur_ff;
               free_in = 1'b1;
            end
         end
         ST_WRITE: begin
            if (!known_ff) begin
               used_in[slot_ff] = 1'b1;
               if (!used_ff[slot_ff]) count_in = COUNT_W'(count_ff + 1'b1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W-RSP_FIELDS_W){1'b0}}, count_ff, known_ff,
                               client_address, slot_oct[SLOT_W-1:0]};
            end
         end
         default: rsp_valid_in = rsp_valid_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      mac_ff      <= mac_in;
      now_ff      <= now_in;
      cur_ff      <= cur_in;
      slot_ff     <= slot_in;
      known_ff    <= known_in;
      free_ff     <= free_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

>>> src/dhcp_lease_allocator.sv
// Allocate: walks the entries one per cycle; a known client ends the walk at its
// entry.
// Release: walks every entry, no response. One request in flight; a response waits in
// its output register while the next request is taken.
// Reset clears used marks, allocation count and response valid and loads the config
// defaults; the RAM needs no clearing pass since used marks gate every entry.
`default_nettype none

module dhcp_lease_allocator #(
   parameter int LEASE_ENTRIES = dla_pkg::LEASE_ENTRIES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [47:0] client_mac, [79:48] now_seconds
   input  wire logic [dla_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] kind
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [3:0] lease_slot, [35:4] client_address, [36] was_known,
   // [68:37] allocation_total, [71:69] zero
   output logic      [dla_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                               csr_wen,
   input  wire logic [dla_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [dla_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import dla_pkg::*;

   localparam int IDX_W = (LEASE_ENTRIES > 1) ? $clog2(LEASE_ENTRIES) : 1;

   logic [ADDR_W-1:0]  server_ff, server_in;
   logic [TIME_W-1:0]  duration_ff, duration_in;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   probe_type          probe;
   logic               probe_used;
   logic [MAC_W-1:0]   key_mac;
   logic [TIME_W-1:0]  key_now;

   always_comb begin
      server_in   = server_ff;
      duration_in = duration_ff;
      if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_SERVER_ADDRESS: server_in   = csr_wdata;
            CSR_LEASE_DURATION: duration_in = csr_wdata;
            default:            server_in   = server_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         server_ff   <= SERVER_RESET;
         duration_ff <= DURATION_RESET;
      end else begin
         server_ff   <= server_in;
         duration_ff <= duration_in;
      end
   end

   dla_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LEASE_ENTRIES),
      .AW    (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dla_cmp u_cmp (
      .entry_data (ram_rd_data),
      .entry_used (probe_used),
      .key_mac    (key_mac),
      .key_now    (key_now),
      .probe      (probe)
   );

   dla_ctrl #(
      .LEASE_ENTRIES (LEASE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_kind       (req_tuser),
      .req_mac        (req_tdata[MAC_W-1:0]),
      .req_now        (req_tdata[REQ_DATA_W-1:MAC_W]),
      .server_address (server_ff),
      .lease_duration (duration_ff),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .probe          (probe),
      .probe_used     (probe_used),
      .key_mac        (key_mac),
      .key_now        (key_now),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> verif/tb_dhcp_lease_allocator.sv
// Self-checking testbench for dhcp_lease_allocator: drives lease requests on the
// request stream, predicts every lease grant and checks the response stream.
// Depends on dla_pkg and the dhcp_lease_allocator RTL only.
`default_nettype none

module tb_dhcp_lease_allocator;
   import dla_pkg::*;

   localparam int LEASE_SLOTS  = LEASE_ENTRIES_DEF;
   localparam int DRAIN_CYCLES = LEASE_SLOTS + 12;
   localparam int MAC_POOL     = 24;
   localparam int MAX_REPORTS  = 10;

   // packed in response order: slot lowest, total highest
   typedef struct packed {
      logic [COUNT_W-1:0] total;
      logic               known;
      logic [ADDR_W-1:0]  addr;
      logic [SLOT_W-1:0]  slot;
   } lease_grant_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_W-1:0]    req_tdata  = '0;
   logic                     req_tuser  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]    rsp_tdata;
   logic                     csr_wen    = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata  = '0;

   // shadow lease table and registers
   logic [MAC_W-1:0]   lease_mac    [LEASE_SLOTS];
   logic [TIME_W-1:0]  lease_expiry [LEASE_SLOTS];
   logic               lease_used   [LEASE_SLOTS];
   logic [COUNT_W-1:0] alloc_count;
   logic [ADDR_W-1:0]  cfg_server;
   logic [TIME_W-1:0]  cfg_duration;

   lease_grant_type    grant_expect[$];
   logic [MAC_W-1:0]   mac_pool[MAC_POOL];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int stall_left     = 0;
   int request_count  = 0;
   int grant_count    = 0;
   int config_count   = 0;
   int mismatch_count = 0;

   dhcp_lease_allocator #(.LEASE_ENTRIES(LEASE_SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("dhcp_lease_allocator verification failed");
      $finish;
   end

   function automatic void reset_lease_table();
      for (int i = 0; i < LEASE_SLOTS; i++) begin
         lease_mac[i]    = '0;
         lease_expiry[i] = '0;
         lease_used[i]   = 1'b0;
      end
      alloc_count  = '0;
      cfg_server   = SERVER_RESET;
      cfg_duration = DURATION_RESET;
   endfunction

   // Update the shadow table for one request; return 1 when a grant follows.
   function automatic bit predict_lease(input kind_type kind, input logic [MAC_W-1:0] mac,
                                        input logic [TIME_W-1:0] now,
                                        output lease_grant_type grant);
      int         slot      = 0;
      bit         known     = 1'b0;
      bit         have_free = 1'b0;
      logic [7:0] low;
      grant = '0;
      if (kind == KIND_RELEASE) begin
         for (int i = 0; i < LEASE_SLOTS; i++)
            if (lease_used[i] && lease_mac[i] == mac) lease_used[i] = 1'b0;
         return 1'b0;
      end
      for (int i = 0; i < LEASE_SLOTS; i++) begin
         if (!known) begin
            if (lease_used[i] && lease_mac[i] == mac) begin
               slot  = i;
               known = 1'b1;
            end else if (!have_free && (!lease_used[i] || lease_expiry[i] < now)) begin
               slot      = i;
               have_free = 1'b1;
            end
         end
      end
      if (!known) begin
         if (!have_free) slot = 0;
         if (!lease_used[slot]) alloc_count = alloc_count + 1'b1;
         lease_mac[slot]  = mac;
         lease_used[slot] = 1'b1;
      end
      lease_expiry[slot] = now + cfg_duration;
      low         = cfg_server[7:0] + 8'd1 + 8'(slot);
      grant.slot  = SLOT_W'(slot);
      grant.addr  = {cfg_server[ADDR_W-1:OCTET_W], low};
      grant.known = known;
      grant.total = alloc_count;
      return 1'b1;
   endfunction

   function automatic void note_mismatch(input string field, input logic [63:0] want,
                                         input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch on grant %0d, %s: expected %0h, got %0h",
                  grant_count, field, want, got);
   endfunction

   // response sink: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_request > 0) begin
         stall_left   = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : grant_check
      lease_grant_type got;
      lease_grant_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RSP_FIELDS_W-1:0];
         if (grant_expect.size() == 0) begin
            note_mismatch("unexpected grant", '0, 64'(got));
         end else begin
            want = grant_expect.pop_front();
            if (got.slot !== want.slot)
               note_mismatch("lease_slot", 64'(want.slot), 64'(got.slot));
            if (got.addr !== want.addr)
               note_mismatch("client_address", 64'(want.addr), 64'(got.addr));
            if (got.known !== want.known)
               note_mismatch("was_known", 64'(want.known), 64'(got.known));
            if (got.total !== want.total)
               note_mismatch("allocation_total", 64'(want.total), 64'(got.total));
            if (rsp_tdata[RSP_DATA_W-1:RSP_FIELDS_W] !== '0)
               note_mismatch("pad bits", '0, 64'(rsp_tdata[RSP_DATA_W-1:RSP_FIELDS_W]));
         end
         grant_count++;
      end
   end

   task automatic send_lease_request(input kind_type kind, input logic [MAC_W-1:0] mac,
                                     input logic [TIME_W-1:0] now);
      lease_grant_type grant;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {now, mac};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (predict_lease(kind, mac, now, grant)) grant_expect.push_back(grant);
      request_count++;
   endtask

   // Drop valid, wait for every grant, then let a trailing release finish.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (grant_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure_lease(input logic [ADDR_W-1:0] server,
                                  input logic [TIME_W-1:0] duration);
      wait_idle();
      csr_wen   <= 1'b1;
      csr_index <= CSR_SERVER_ADDRESS;
      csr_wdata <= server;
      @(posedge clock);
      csr_index <= CSR_LEASE_DURATION;
      csr_wdata <= duration;
      @(posedge clock);
      csr_wen      <= 1'b0;
      cfg_server   = server;
      cfg_duration = duration;
      config_count++;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // Mostly a small client pool with a creeping clock; a little pure noise.
   task automatic run_lease_traffic(input int count);
      logic [TIME_W-1:0] now;
      logic [MAC_W-1:0]  mac;
      kind_type          kind;
      now = $urandom;
      for (int i = 0; i < MAC_POOL; i++) mac_pool[i] = MAC_W'({$urandom, $urandom});
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 4) begin
            send_lease_request(kind_type'($urandom_range(1)), MAC_W'({$urandom, $urandom}),
                               $urandom);
         end else begin
            if ($urandom_range(99) < 3) now = now + $urandom_range(5000);
            else now = now + $urandom_range(8);
            mac  = mac_pool[$urandom_range(MAC_POOL - 1)];
            kind = ($urandom_range(99) < 20) ? KIND_RELEASE : KIND_ALLOCATE;
            send_lease_request(kind, mac, now);
         end
      end
   endtask

   task automatic test_reset_defaults();
      send_lease_request(KIND_ALLOCATE, 48'h0000_0000_0001, 32'd5);
      send_lease_request(KIND_RELEASE, 48'h0000_0000_0001, 32'd6);
   endtask

   task automatic test_directed();
      // low octet 0xFE makes slot 1 onward wrap the host byte
      configure_lease(32'hC0A8_01FE, 32'd100);
      send_lease_request(KIND_ALLOCATE, 48'h0000_0000_00A0, 32'd0);
      send_lease_request(KIND_ALLOCATE, 48'h0000_0000_00A0, 32'd10);
      for (int i = 1; i < LEASE_SLOTS; i++)
         send_lease_request(KIND_ALLOCATE, 48'h0000_0000_00A0 + i, 32'd20);
      // table full, slot 0 expires exactly now and still counts as live: no free entry, so overwrite slot 0
      send_lease_request(KIND_ALLOCATE, 48'h0000_0000_0BEE, 32'd110);
      send_lease_request(KIND_RELEASE, 48'h0000_0000_0DED, 32'd111);
      send_lease_request(KIND_RELEASE, 48'h0000_0000_00A3, 32'd112);
      send_lease_request(KIND_ALLOCATE, 48'h0000_0000_00A3, 32'd113);
      send_lease_request(KIND_ALLOCATE, 48'h0000_0000_CAFE, 32'd121);
      send_lease_request(KIND_ALLOCATE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send_lease_request(KIND_ALLOCATE, 48'h0000_0000_0000, 32'h0000_0000);
   endtask

   task automatic test_no_idling();
      set_idling(0, 0);
      configure_lease(32'hFFFF_FFFF, 32'd0);
      run_lease_traffic(280);
   endtask

   task automatic test_sender_idle();
      configure_lease($urandom, 32'hFFFF_FFFF);
      set_idling(50, 0);
      run_lease_traffic(280);
   endtask

   task automatic test_receiver_stall();
      configure_lease($urandom, $urandom_range(1, 40));
      set_idling(0, 50);
      run_lease_traffic(280);
   endtask

   task automatic test_both_idle();
      configure_lease(32'h0000_0000, 32'd3600);
      set_idling(18, 18);
      run_lease_traffic(280);
   endtask

   task automatic test_backpressure();
      configure_lease($urandom, $urandom_range(1, 60));
      set_idling(0, 0);
      // hold the response side long enough that requests back up
      hold_request = 400;
      run_lease_traffic(40);
      run_lease_traffic(80);
   endtask

   task automatic test_config_sweep();
      logic [TIME_W-1:0] duration;
      set_idling(18, 18);
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: duration = 32'd0;
            1: duration = $urandom_range(1, 30);
            2: duration = 32'hFFFF_FFFF;
            default: duration = $urandom;
         endcase
         configure_lease($urandom, duration);
         run_lease_traffic(90);
      end
   endtask

   initial begin
      reset_lease_table();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed();
      test_no_idling();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_backpressure();
      test_config_sweep();
      set_idling(0, 0);
      wait_idle();
      $display("Ran %0d lease requests through %0d register settings; %0d grants checked.",
               request_count, config_count, grant_count);
      $display("Mismatches: %0d, grants still outstanding: %0d.",
               mismatch_count, grant_expect.size());
      if (mismatch_count == 0 && grant_expect.size() == 0) begin
         $display("dhcp_lease_allocator verification clean");
      end else begin
         $display("dhcp_lease_allocator verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
src/dla_pkg.sv
src/dla_ram.sv
src/dla_cmp.sv
src/dla_ctrl.sv
src/dhcp_lease_allocator.sv
verif/tb_dhcp_lease_allocator.sv
